// File: sv/shd_pkg.sv
`timescale 1ns / 1ps
package shd_pkg;

   localparam int SHADE_ROWS_DEFAULT = 64;
   localparam int MAX_BLOCK_DEFAULT  = 16;
   localparam int LIGHT_W            = 16;
   localparam int CORNER_W           = 14;
   localparam int TEXEL_W            = 8;
   localparam int ENTRY_ADDR_W       = 16;
   localparam int SIZE_W             = 5;
   localparam int QUEUE_DEPTH        = 4;
   localparam logic [LIGHT_W-1:0] SHADE_MASK = 16'hFF00;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_TEXEL = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [13:0]         table_address;
      logic [7:0]          table_value;
      logic [CORNER_W-1:0] top_left_light;
      logic [CORNER_W-1:0] top_right_light;
      logic [CORNER_W-1:0] bottom_left_light;
      logic [CORNER_W-1:0] bottom_right_light;
      logic [TEXEL_W-1:0]  texel;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] shaded_pixel;
      logic       row_end;
      logic       block_end;
   } rsp_beat_type;

   typedef logic [1:0] csr_beat_type;

   // one colormap access handed from front to back
   typedef struct packed {
      logic                    is_write;
      logic [ENTRY_ADDR_W-1:0] addr;
      logic [7:0]              data;
      logic                    row_end;
      logic                    block_end;
   } entry_type;

endpackage

// File: sv/shd_if.sv
`timescale 1ns / 1ps
interface shd_req_if;
   logic                       valid;
   logic                       ready;
   shd_pkg::req_beat_type      payload;
   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

interface shd_rsp_if;
   logic                       valid;
   logic                       ready;
   shd_pkg::rsp_beat_type      payload;
   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

interface shd_csr_if;
   logic                       valid;
   logic                       ready;
   shd_pkg::csr_beat_type      payload;
   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

// File: sv/shd_front.sv
`timescale 1ns / 1ps
module shd_front #(
   parameter int SHADE_ROWS = shd_pkg::SHADE_ROWS_DEFAULT,
   parameter int MAX_BLOCK  = shd_pkg::MAX_BLOCK_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   shd_req_if.sink             req_if,
   shd_csr_if.sink             csr_if,
   input  logic                q_full,
   output logic                q_push,
   output shd_pkg::entry_type  q_entry
);

   localparam int CW         = $clog2(MAX_BLOCK);
   localparam int STORE_SIZE = SHADE_ROWS * 256;
   localparam int RW         = $clog2(SHADE_ROWS);
   localparam int LW         = shd_pkg::LIGHT_W;

   logic [1:0]    mip_ff;
   logic [LW-1:0] left_ff, left_in;
   logic [LW-1:0] right_ff, right_in;
   logic [LW-1:0] lstep_ff, lstep_in;
   logic [LW-1:0] rstep_ff, rstep_in;
   logic [LW-1:0] span_ff, span_in;
   logic [LW-1:0] sstep_ff, sstep_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;

   logic                      fire;
   logic [2:0]                sh;
   logic [shd_pkg::SIZE_W-1:0] size;
   logic signed [LW:0]        dl, dr, ds;
   logic signed [LW:0]        dl_sh, dr_sh, ds_sh;
   logic [LW-1:0]             light_cur, step_cur, masked;
   logic [7:0]                shade_raw, shade_row;
   logic [CW:0]               col_inc;
   logic [CW:0]               row_inc;
   logic                      rend, bend;
   logic                      load_ok;
   shd_pkg::req_beat_type     beat;

   assign beat          = req_if.payload;
   assign req_if.ready  = !q_full;
   assign csr_if.ready  = 1'b1;
   assign fire          = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mip_ff <= '0;
      end else if (csr_if.valid) begin
         mip_ff <= csr_if.payload;
      end
   end

   always_comb begin
      sh   = 3'd4 - {1'b0, mip_ff};
      size = shd_pkg::SIZE_W'(16) >> mip_ff;
      if (size > shd_pkg::SIZE_W'(MAX_BLOCK)) begin
         size = shd_pkg::SIZE_W'(MAX_BLOCK);
      end

      dl    = $signed({3'b000, beat.bottom_left_light}) - $signed({3'b000, beat.top_left_light});
      dr    = $signed({3'b000, beat.bottom_right_light})
              - $signed({3'b000, beat.top_right_light});
      ds    = $signed({left_ff[LW-1], left_ff}) - $signed({right_ff[LW-1], right_ff});
      dl_sh = dl >>> sh;
      dr_sh = dr >>> sh;
      ds_sh = ds >>> sh;

      light_cur = (col_ff == '0) ? right_ff : span_ff;
      step_cur  = (col_ff == '0) ? ds_sh[LW-1:0] : sstep_ff;

      masked    = light_cur & shd_pkg::SHADE_MASK;
      shade_raw = {1'b0, masked[14:8]};
      if (light_cur[LW-1]) begin
         shade_row = '0;
      end else if (shade_raw > 8'(SHADE_ROWS - 1)) begin
         shade_row = 8'(SHADE_ROWS - 1);
      end else begin
         shade_row = shade_raw;
      end

      col_inc = {1'b0, col_ff} + 1'b1;
      row_inc = {1'b0, row_ff} + 1'b1;
      rend    = shd_pkg::SIZE_W'(col_inc) >= size;
      bend    = rend && (shd_pkg::SIZE_W'(row_inc) >= size);
      load_ok = 17'(beat.table_address) < 17'(STORE_SIZE);
   end

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      lstep_in = lstep_ff;
      rstep_in = rstep_ff;
      span_in  = span_ff;
      sstep_in = sstep_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      q_push   = 1'b0;
      q_entry  = '0;
      unique case (beat.opcode)
         shd_pkg::OP_LOAD: begin
            q_push           = fire && load_ok;
            q_entry.is_write = 1'b1;
            q_entry.addr     = shd_pkg::ENTRY_ADDR_W'(beat.table_address);
            q_entry.data     = beat.table_value;
         end
         shd_pkg::OP_START: begin
            left_in  = LW'(beat.top_left_light);
            right_in = LW'(beat.top_right_light);
            lstep_in = dl_sh[LW-1:0];
            rstep_in = dr_sh[LW-1:0];
            col_in   = '0;
            row_in   = '0;
         end
         shd_pkg::OP_TEXEL: begin
            q_push            = fire;
            q_entry.is_write  = 1'b0;
            q_entry.addr      = shd_pkg::ENTRY_ADDR_W'({shade_row[RW-1:0], beat.texel});
            q_entry.row_end   = rend;
            q_entry.block_end = bend;
            span_in  = light_cur + step_cur;
            sstep_in = step_cur;
            col_in   = rend ? '0 : col_inc[CW-1:0];
            if (rend) begin
               left_in  = left_ff + lstep_ff;
               right_in = right_ff + rstep_ff;
               row_in   = bend ? '0 : row_inc[CW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= '0;
         lstep_ff <= '0;
         rstep_ff <= '0;
         span_ff  <= '0;
         sstep_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (fire) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         lstep_ff <= lstep_in;
         rstep_ff <= rstep_in;
         span_ff  <= span_in;
         sstep_ff <= sstep_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

endmodule

// File: sv/shd_queue.sv
`timescale 1ns / 1ps
module shd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  shd_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output shd_pkg::entry_type  head_entry
);

   localparam int PW = $clog2(shd_pkg::QUEUE_DEPTH);

   shd_pkg::entry_type slot_ff [shd_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]        count_ff;
   logic               do_pop;

   assign full       = count_ff == (PW + 1)'(shd_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: sv/shd_back.sv
`timescale 1ns / 1ps
module shd_back #(
   parameter int SHADE_ROWS = shd_pkg::SHADE_ROWS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  shd_pkg::entry_type  head_entry,
   output logic                pop,
   shd_rsp_if.source           rsp_if
);

   localparam int DEPTH = SHADE_ROWS * 256;
   localparam int AW    = $clog2(DEPTH);

   logic [7:0]    colormap_ff [DEPTH];
   logic [7:0]    rd_data_ff;
   logic          out_valid_ff;
   logic          row_end_ff, block_end_ff;
   logic          wr_en, rd_en;
   logic [AW-1:0] idx;

   assign idx   = head_entry.addr[AW-1:0];
   assign wr_en = head_valid && head_entry.is_write;
   assign rd_en = head_valid && !head_entry.is_write && (!out_valid_ff || rsp_if.ready);
   assign pop   = wr_en || rd_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         colormap_ff[idx] <= head_entry.data;
      end
      if (rd_en) begin
         rd_data_ff   <= colormap_ff[idx];
         row_end_ff   <= head_entry.row_end;
         block_end_ff <= head_entry.block_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rd_en) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_if.valid                = out_valid_ff;
   assign rsp_if.payload.shaded_pixel = rd_data_ff;
   assign rsp_if.payload.row_end      = row_end_ff;
   assign rsp_if.payload.block_end    = block_end_ff;

endmodule

// File: sv/surface_block_light_shader.sv
`timescale 1ns / 1ps
// Shades square lightmapped surface blocks through a loaded colormap. Send
// colormap loads (opcode 0), a block start with the four corner lights
// (opcode 1) and texels (opcode 2, rows top to bottom, each row right to
// left); every texel returns one beat with the lit palette index and
// row/block end flags. One request beat is taken per cycle when the rsp side
// keeps up; a texel's result passes through the four-entry queue and then
// the registered colormap read on the single memory port. Loads and texels
// share that queue, so a lookup always sees every earlier load. The user
// must write mip_level through the csr channel only while the block is
// idle, which the block itself does not enforce; colormap entries must be
// loaded before they are looked up.
module surface_block_light_shader #(
   parameter int SHADE_ROWS = shd_pkg::SHADE_ROWS_DEFAULT,
   parameter int MAX_BLOCK  = shd_pkg::MAX_BLOCK_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   shd_req_if.sink    req_if,
   shd_rsp_if.source  rsp_if,
   shd_csr_if.sink    csr_if
);

   logic               q_push, q_full, q_pop, q_valid;
   shd_pkg::entry_type q_in, q_head;

   shd_front #(
      .SHADE_ROWS(SHADE_ROWS),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .csr_if (csr_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_entry(q_in)
   );

   shd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_entry(q_head)
   );

   shd_back #(
      .SHADE_ROWS(SHADE_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(q_valid),
      .head_entry(q_head),
      .pop       (q_pop),
      .rsp_if    (rsp_if)
   );

endmodule

// File: sv/shd_checker.sv
`timescale 1ns / 1ps
module shd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [1:0]            req_opcode,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input shd_pkg::rsp_beat_type rsp_payload
);

   logic       req_texel, rsp_fire;
   logic [3:0] pending_ff;

   assign req_texel = req_valid && req_ready && (req_opcode == shd_pkg::OP_TEXEL);
   assign rsp_fire  = rsp_valid && rsp_ready;

   // texels taken whose result beat has not gone out yet
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_texel && !rsp_fire) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (!req_texel && rsp_fire) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   a_block_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.block_end |-> rsp_payload.row_end)
      else $error("block end without row end");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pending_ff != 4'd0)
      else $error("rsp beat without a texel");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'(shd_pkg::QUEUE_DEPTH + 1))
      else $error("too many texels in flight");

endmodule

bind surface_block_light_shader shd_checker u_shd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .req_opcode (req_if.payload.opcode),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_payload(rsp_if.payload)
);

// File: verif/tb_surface_block_light_shader.sv
`timescale 1ns / 1ps
module tb_surface_block_light_shader;
   import shd_pkg::*;

   localparam int         SHADE_ROWS    = SHADE_ROWS_DEFAULT;
   localparam int         STORE_SIZE    = SHADE_ROWS * 256;
   localparam int         ITEM_TARGET   = 650;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         TAIL_CYCLES   = 12;
   localparam int         STALL_LIMIT   = 1000;
   localparam logic [1:0] OP_IGNORED    = 2'd3;

   typedef struct {
      bit           is_mip;
      logic [1:0]   mip;
      req_beat_type beat;
      bit           typed;
      rsp_beat_type want;
   } plan_row_type;

   logic clock;
   logic reset;

   shd_req_if req_if();
   shd_rsp_if rsp_if();
   shd_csr_if csr_if();

   surface_block_light_shader uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // shading state mirrored from the block
   logic [7:0]   cmap_mirror [STORE_SIZE];
   bit           cmap_loaded [STORE_SIZE];
   logic [1:0]   mip_cfg;
   logic [15:0]  left_light, right_light, left_step, right_step;
   logic [15:0]  span_light, span_step;
   logic [3:0]   col_cnt, row_cnt;

   rsp_beat_type lit_pixel_q[$];
   plan_row_type directed_plan[$];
   int           bad_beats   = 0;
   int           items_sent  = 0;
   int           idle_cycles = 0;
   bit           sender_calm = 1'b0;
   bit           rsp_calm    = 1'b0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int shade_index(input logic [15:0] light, input logic [7:0] tex);
      int shade_row;
      if (light[15]) shade_row = 0;
      else shade_row = int'(light[15:8]);
      if (shade_row >= SHADE_ROWS) shade_row = SHADE_ROWS - 1;
      return shade_row * 256 + int'(tex);
   endfunction

   function automatic req_beat_type scrambled_beat(input logic [1:0] op);
      req_beat_type b;
      b.opcode             = op;
      b.table_address      = 14'($urandom_range(0, 16383));
      b.table_value        = 8'($urandom_range(0, 255));
      b.top_left_light     = 14'($urandom_range(0, 16383));
      b.top_right_light    = 14'($urandom_range(0, 16383));
      b.bottom_left_light  = 14'($urandom_range(0, 16383));
      b.bottom_right_light = 14'($urandom_range(0, 16383));
      b.texel              = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [13:0] corner_light();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         default: return 14'($urandom_range(0, 16383));
      endcase
   endfunction

   function automatic plan_row_type blank_row(input logic [1:0] op);
      plan_row_type r;
      r.is_mip = 1'b0;
      r.mip    = '0;
      r.beat   = scrambled_beat(op);
      r.typed  = 1'b0;
      r.want   = '0;
      return r;
   endfunction

   function automatic plan_row_type load_row(input int addr, input logic [7:0] val);
      plan_row_type r;
      r = blank_row(OP_LOAD);
      r.beat.table_address = 14'(addr);
      r.beat.table_value   = val;
      return r;
   endfunction

   function automatic plan_row_type start_row(input logic [13:0] top, input logic [13:0] bottom);
      plan_row_type r;
      r = blank_row(OP_START);
      r.beat.top_left_light     = top;
      r.beat.top_right_light    = top;
      r.beat.bottom_left_light  = bottom;
      r.beat.bottom_right_light = bottom;
      return r;
   endfunction

   function automatic plan_row_type texel_row(input logic [7:0] tex);
      plan_row_type r;
      r = blank_row(OP_TEXEL);
      r.beat.texel = tex;
      return r;
   endfunction

   function automatic plan_row_type lit_row(input logic [7:0] tex, input logic [7:0] pix,
                                            input bit re, input bit be);
      plan_row_type r;
      r = texel_row(tex);
      r.typed             = 1'b1;
      r.want.shaded_pixel = pix;
      r.want.row_end      = re;
      r.want.block_end    = be;
      return r;
   endfunction

   function automatic plan_row_type mip_row(input logic [1:0] lvl);
      plan_row_type r;
      r = blank_row(OP_IGNORED);
      r.is_mip = 1'b1;
      r.mip    = lvl;
      return r;
   endfunction

   task automatic shade_model(input req_beat_type b, output bit produced, output rsp_beat_type r);
      int sh, size, gap_light, nxt_col, nxt_row;
      sh       = 4 - int'(mip_cfg);
      size     = 16 >> mip_cfg;
      produced = 1'b0;
      r        = '0;
      case (b.opcode)
         OP_LOAD: begin
            if (int'(b.table_address) < STORE_SIZE) begin
               cmap_mirror[b.table_address] = b.table_value;
               cmap_loaded[b.table_address] = 1'b1;
            end
         end
         OP_START: begin
            left_light  = 16'(b.top_left_light);
            right_light = 16'(b.top_right_light);
            left_step   = 16'((int'(b.bottom_left_light) - int'(b.top_left_light)) >>> sh);
            right_step  = 16'((int'(b.bottom_right_light) - int'(b.top_right_light)) >>> sh);
            col_cnt     = '0;
            row_cnt     = '0;
         end
         OP_TEXEL: begin
            if (col_cnt == 0) begin
               gap_light  = int'($signed(left_light)) - int'($signed(right_light));
               span_light = right_light;
               span_step  = 16'(gap_light >>> sh);
            end
            produced       = 1'b1;
            r.shaded_pixel = cmap_mirror[shade_index(span_light, b.texel)];
            span_light     = span_light + span_step;
            nxt_col        = int'(col_cnt) + 1;
            if (nxt_col >= size) begin
               r.row_end   = 1'b1;
               nxt_col     = 0;
               left_light  = left_light + left_step;
               right_light = right_light + right_step;
               nxt_row     = int'(row_cnt) + 1;
               if (nxt_row >= size) begin
                  r.block_end = 1'b1;
                  nxt_row     = 0;
               end
               row_cnt = 4'(nxt_row);
            end
            col_cnt = 4'(nxt_col);
         end
         default: ;
      endcase
   endtask

   task automatic send_beat(input req_beat_type b, input bit typed, input rsp_beat_type want);
      int gap;
      bit produced;
      rsp_beat_type lit;
      gap = sender_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= b;
      do @(posedge clock); while (!req_if.ready);
      shade_model(b, produced, lit);
      if (b.opcode != OP_IGNORED) items_sent++;
      if (produced) lit_pixel_q.push_back(typed ? want : lit);
   endtask

   // a texel is sent only once its colormap entry holds a value
   task automatic send_item(input req_beat_type b, input bit typed, input rsp_beat_type want);
      req_beat_type fill;
      int slot;
      if (b.opcode == OP_TEXEL) begin
         slot = shade_index((col_cnt == 0) ? right_light : span_light, b.texel);
         if (!cmap_loaded[slot]) begin
            fill = scrambled_beat(OP_LOAD);
            fill.table_address = 14'(slot);
            send_beat(fill, 1'b0, want);
         end
      end
      send_beat(b, typed, want);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (lit_pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mip(input logic [1:0] lvl);
      drain();
      csr_if.valid   <= 1'b1;
      csr_if.payload <= lvl;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      mip_cfg = lvl;
   endtask

   task automatic run_block(input int size);
      req_beat_type b;
      logic [7:0] palette [4];
      int n, base;
      b = scrambled_beat(OP_START);
      if (size == 16) begin
         // keep the largest block to a few shade rows
         base = $urandom_range(0, 16383 - 512);
         b.top_left_light     = 14'(base + $urandom_range(0, 512));
         b.top_right_light    = 14'(base + $urandom_range(0, 512));
         b.bottom_left_light  = 14'(base + $urandom_range(0, 512));
         b.bottom_right_light = 14'(base + $urandom_range(0, 512));
      end else begin
         b.top_left_light     = corner_light();
         b.top_right_light    = corner_light();
         b.bottom_left_light  = corner_light();
         b.bottom_right_light = corner_light();
      end
      send_item(b, 1'b0, '0);
      foreach (palette[i]) palette[i] = 8'($urandom_range(0, 255));
      n = size * size;
      case ($urandom_range(0, 9))
         0, 1: n += $urandom_range(1, (size == 16) ? 8 : 3 * size);
         2: n = $urandom_range(1, n - 1);
         default: ;
      endcase
      repeat (n) begin
         b = scrambled_beat(OP_TEXEL);
         b.texel = palette[$urandom_range(0, 3)];
         send_item(b, 1'b0, '0);
      end
   endtask

   task automatic run_sequence(input int size);
      int pick;
      logic [1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         run_block(size);
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 4)) send_item(scrambled_beat(OP_LOAD), 1'b0, '0);
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 3)) begin
            op = OP_TEXEL;
            if ($urandom_range(0, 1)) op = OP_IGNORED;
            send_item(scrambled_beat(op), 1'b0, '0);
         end
      end else begin
         drain();
      end
   endtask

   initial begin : stimulus
      int lvl, phase;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      mip_cfg     = '0;
      left_light  = '0;
      right_light = '0;
      left_step   = '0;
      right_step  = '0;
      span_light  = '0;
      span_step   = '0;
      col_cnt     = '0;
      row_cnt     = '0;

      directed_plan.push_back(load_row(16'h0000, 8'hA5));
      directed_plan.push_back(load_row(16'h00FF, 8'hFF));
      directed_plan.push_back(load_row(16'h3FFF, 8'h5A));
      // texels before any block start use the zero lights
      directed_plan.push_back(lit_row(8'h00, 8'hA5, 1'b0, 1'b0));
      directed_plan.push_back(lit_row(8'hFF, 8'hFF, 1'b0, 1'b0));
      directed_plan.push_back(blank_row(OP_IGNORED));
      directed_plan[$].beat = '1;
      directed_plan.push_back(start_row(14'h3FFF, 14'h3FFF));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b0, 1'b0));
      // shrink the block mid-row
      directed_plan.push_back(mip_row(2'd3));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b1, 1'b0));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b0, 1'b0));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b1, 1'b1));
      // falling edges run past the block end into negative light
      directed_plan.push_back(start_row(14'h3FFF, 14'h0000));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b0, 1'b0));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b1, 1'b0));
      directed_plan.push_back(texel_row(8'h80));
      directed_plan.push_back(texel_row(8'h80));
      directed_plan.push_back(lit_row(8'hFF, 8'hFF, 1'b0, 1'b0));
      directed_plan.push_back(lit_row(8'hFF, 8'hFF, 1'b1, 1'b0));
      // rising edges run past the last shade row
      directed_plan.push_back(start_row(14'h0000, 14'h3FFF));
      directed_plan.push_back(lit_row(8'hFF, 8'hFF, 1'b0, 1'b0));
      directed_plan.push_back(lit_row(8'hFF, 8'hFF, 1'b1, 1'b0));
      directed_plan.push_back(texel_row(8'h80));
      directed_plan.push_back(texel_row(8'h80));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b0, 1'b0));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b1, 1'b0));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b0, 1'b0));
      directed_plan.push_back(lit_row(8'hFF, 8'h5A, 1'b1, 1'b1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_mip) set_mip(directed_plan[i].mip);
         else send_item(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: lvl = 3;
            1: lvl = 0;
            2: lvl = 1;
            3: lvl = 2;
            default: lvl = $urandom_range(1, 3);
         endcase
         set_mip(2'(lvl));
         sender_calm = ($urandom_range(0, 3) == 0);
         rsp_calm    = ($urandom_range(0, 3) == 0);
         if (lvl == 0) begin
            run_block(16);
         end else begin
            repeat ($urandom_range(2, 6))
               if (items_sent < ITEM_TARGET) run_sequence(16 >> lvl);
         end
         phase++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_beats == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin : receiver
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   always @(posedge clock) begin : pixel_check
      rsp_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (lit_pixel_q.size() == 0) begin
            $error("result beat with none pending: shaded_pixel %0h",
                   rsp_if.payload.shaded_pixel);
            bad_beats++;
         end else begin
            want = lit_pixel_q.pop_front();
            if (rsp_if.payload.shaded_pixel !== want.shaded_pixel) begin
               $error("shaded_pixel: expected %0h, got %0h", want.shaded_pixel,
                      rsp_if.payload.shaded_pixel);
               bad_beats++;
            end
            if (rsp_if.payload.row_end !== want.row_end) begin
               $error("row_end: expected %0b, got %0b", want.row_end, rsp_if.payload.row_end);
               bad_beats++;
            end
            if (rsp_if.payload.block_end !== want.block_end) begin
               $error("block_end: expected %0b, got %0b", want.block_end,
                      rsp_if.payload.block_end);
               bad_beats++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
